// ----- src/bdeq_pkg.sv -----
// Package for the bounded double-ended queue.
// Holds the storage sizes, field widths and command codes used across the design.
// Depends on nothing.
package bdeq_pkg;

   // Built storage depth and derived widths.
   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int CAP_W  = 5;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DATA_W-1:0] data_type;

endpackage

// ----- src/bounded_double_ended_queue.sv -----
// Top level of the bounded double-ended queue: a circular buffer in one
// synchronous memory, with head, tail and count registers and a response stage.
// Depends on bdeq_pkg.
//
//   channel   direction  handshake              payload
//   request   in         start, busy            req_cmd, req_item_value
//   response  out        rsp_valid (strobe)     rsp_ok, rsp_front_value, rsp_rear_value,
//                                               rsp_is_empty, rsp_is_full, rsp_entry_count
//   csr       in         csr_valid, csr_ready   csr_queue_capacity
//
// An item can be accepted every cycle; its response is on the outputs in the cycle
// right after the acceptance edge. The latency is set by the registered read of the
// entry memory, which is issued at the acceptance edge at the new front and rear
// addresses, with forwarding of the entry written at that same edge. Reset empties the
// queue and sets capacity to the built depth; busy is high only during reset. The
// receiver cannot stall. A csr write empties the queue and is taken only when no item
// is offered and no response is on the outputs.
module bounded_double_ended_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [bdeq_pkg::CMD_W-1:0]       req_cmd,
   input  logic signed [bdeq_pkg::DATA_W-1:0] req_item_value,
   output logic                             rsp_valid,
   output logic                             rsp_ok,
   output logic signed [bdeq_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [bdeq_pkg::DATA_W-1:0] rsp_rear_value,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full,
   output logic [bdeq_pkg::CNT_W-1:0]       rsp_entry_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bdeq_pkg::CAP_W-1:0]       csr_queue_capacity
);

   // Pointer steps that wrap around the built depth.
   function automatic bdeq_pkg::idx_type idx_inc(input bdeq_pkg::idx_type i);
      if (i == bdeq_pkg::idx_type'(bdeq_pkg::DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   function automatic bdeq_pkg::idx_type idx_dec(input bdeq_pkg::idx_type i);
      if (i == '0) begin
         return bdeq_pkg::idx_type'(bdeq_pkg::DEPTH - 1);
      end
      return i - 1'b1;
   endfunction

   // Entry memory.
   bdeq_pkg::data_type entry_mem [bdeq_pkg::DEPTH];

   // Queue state.
   bdeq_pkg::idx_type          head_ff, head_in;
   bdeq_pkg::idx_type          tail_ff, tail_in;
   bdeq_pkg::cnt_type          count_ff, count_in;
   logic [bdeq_pkg::CAP_W-1:0] cap_ff;

   // Response stage.
   logic               rsp_valid_ff;
   logic               ok_ff, ok_in;
   logic               empty_ff;
   logic               full_ff;
   bdeq_pkg::cnt_type  rsp_count_ff;
   bdeq_pkg::data_type rd_front_ff, rd_rear_ff;
   bdeq_pkg::data_type wdata_ff;
   logic               fwd_front_ff, fwd_rear_ff;

   // Per-item control.
   logic               accept;
   logic               cfg_write;
   logic               wr_en;
   bdeq_pkg::idx_type  wr_addr;
   bdeq_pkg::idx_type  rear_addr;
   bdeq_pkg::cnt_type  cap_used;
   logic               is_full_now;
   logic               is_empty_now;

   // Items are held off only during reset; a csr write waits until no item is
   // offered and no response is pending, so it never overlaps an item.
   assign busy      = reset;
   assign csr_ready = !reset && !start && !rsp_valid_ff;
   assign accept    = start && !busy;
   assign cfg_write = csr_valid && csr_ready;

   // Clamp the capacity register into 1..DEPTH.
   always_comb begin
      if (cap_ff == '0) begin
         cap_used = bdeq_pkg::cnt_type'(1);
      end else if (bdeq_pkg::CNT_W'(cap_ff) > bdeq_pkg::cnt_type'(bdeq_pkg::DEPTH)) begin
         cap_used = bdeq_pkg::cnt_type'(bdeq_pkg::DEPTH);
      end else begin
         cap_used = bdeq_pkg::CNT_W'(cap_ff);
      end
   end

   assign is_full_now  = count_ff >= cap_used;
   assign is_empty_now = count_ff == '0;

   // Command decode: new pointers, count and the memory write.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ok_in    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      case (req_cmd)
         bdeq_pkg::CMD_PUSH_FRONT: begin
            if (!is_full_now) begin
               head_in  = idx_dec(head_ff);
               wr_addr  = idx_dec(head_ff);
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               ok_in    = 1'b1;
            end
         end
         bdeq_pkg::CMD_PUSH_REAR: begin
            if (!is_full_now) begin
               wr_addr  = tail_ff;
               tail_in  = idx_inc(tail_ff);
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               ok_in    = 1'b1;
            end
         end
         bdeq_pkg::CMD_POP_FRONT: begin
            if (!is_empty_now) begin
               head_in  = idx_inc(head_ff);
               count_in = count_ff - 1'b1;
               ok_in    = 1'b1;
            end
         end
         bdeq_pkg::CMD_POP_REAR: begin
            if (!is_empty_now) begin
               tail_in  = idx_dec(tail_ff);
               count_in = count_ff - 1'b1;
               ok_in    = 1'b1;
            end
         end
         bdeq_pkg::CMD_PEEK: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // The rear entry sits just before the tail slot.
   assign rear_addr = idx_dec(tail_in);

   // Memory: write the inserted item and read the new front and rear entries.
   // A read at the address written in the same cycle returns old data, so the
   // written item is forwarded in that case.
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         entry_mem[wr_addr] <= req_item_value;
      end
      if (accept) begin
         rd_front_ff  <= entry_mem[head_in];
         rd_rear_ff   <= entry_mem[rear_addr];
         wdata_ff     <= req_item_value;
         fwd_front_ff <= wr_en && (wr_addr == head_in);
         fwd_rear_ff  <= wr_en && (wr_addr == rear_addr);
         ok_ff        <= ok_in;
         empty_ff     <= count_in == '0;
         full_ff      <= count_in >= cap_used;
         rsp_count_ff <= count_in;
      end
   end

   // Pointer, count and capacity registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= bdeq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept && !cfg_write;
         if (cfg_write) begin
            cap_ff   <= csr_queue_capacity;
            head_ff  <= '0;
            tail_ff  <= '0;
            count_ff <= '0;
         end else if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   // Response outputs; an empty queue reports minus one for both ends.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_front_value = empty_ff ? -32'sd1 :
                            (fwd_front_ff ? wdata_ff : rd_front_ff);
   assign rsp_rear_value  = empty_ff ? -32'sd1 :
                            (fwd_rear_ff ? wdata_ff : rd_rear_ff);

   // Expected tail from head and count, for the pointer check below.
   logic [bdeq_pkg::CNT_W:0] ptr_sum;
   bdeq_pkg::idx_type        tail_expect;
   assign ptr_sum     = {1'b0, bdeq_pkg::CNT_W'(head_ff)} + {1'b0, count_ff};
   assign tail_expect = (ptr_sum >= (bdeq_pkg::CNT_W+1)'(bdeq_pkg::DEPTH))
                        ? bdeq_pkg::idx_type'(ptr_sum - (bdeq_pkg::CNT_W+1)'(bdeq_pkg::DEPTH))
                        : bdeq_pkg::idx_type'(ptr_sum);

   // The count never exceeds the clamped capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= cap_used)
      else $error("entry count above capacity");

   // The tail always sits count entries past the head.
   assert property (@(posedge clock) disable iff (reset) tail_ff == tail_expect)
      else $error("head, tail and count disagree");

   // Every accepted item yields exactly one response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !cfg_write) |=> rsp_valid)
      else $error("accepted item produced no response");

   // An empty response always reports a zero count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_entry_count == '0))
      else $error("empty response with nonzero count");

   // A capacity write leaves the queue empty.
   assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> (count_ff == '0))
      else $error("capacity write did not empty the queue");

endmodule
